[rtl/eamf_pkg.sv]
// ---------------------------------------------------------------------------
// eamf_pkg
// Shared widths, register indexes and divider constants for the 3x3 mean
// filter.
// ---------------------------------------------------------------------------
package eamf_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
   localparam int COL_BITS    = ADDR_BITS + 1;
   localparam int WIDTH_BITS  = 13;
   localparam int HEIGHT_BITS = 16;
   localparam int ROW_BITS    = HEIGHT_BITS + 2;
   localparam int SUM_BITS    = SAMPLE_BITS + 4;

   // reciprocal divide: floor(x * floor(2^S / n) / 2^S) is exact or one low
   localparam int RECIP_SHIFT = SUM_BITS;
   localparam int RECIP_BITS  = SUM_BITS - 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

   localparam logic [RECIP_BITS-1:0] RECIP_4 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 4);
   localparam logic [RECIP_BITS-1:0] RECIP_6 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 6);
   localparam logic [RECIP_BITS-1:0] RECIP_9 = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 9);

   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(2049);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(2049);

   // csr register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // request action codes
   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // in-bounds neighbor count codes
   localparam logic [1:0] CNT_4 = 2'd0;
   localparam logic [1:0] CNT_6 = 2'd1;
   localparam logic [1:0] CNT_9 = 2'd2;

   typedef struct packed {
      logic col_lo;
      logic col_hi;
      logic row_lo;
      logic row_hi;
      logic last;
   } pix_info_type;

   function automatic logic [1:0] count_code(input logic col_full, input logic row_full);
      logic [1:0] code;
      if (col_full && row_full) begin
         code = CNT_9;
      end else if (col_full || row_full) begin
         code = CNT_6;
      end else begin
         code = CNT_4;
      end
      return code;
   endfunction

   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [1:0] code);
      logic [RECIP_BITS-1:0] r;
      case (code)
         CNT_9:   r = RECIP_9;
         CNT_6:   r = RECIP_6;
         default: r = RECIP_4;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] divisor_of(input logic [1:0] code);
      logic [3:0] d;
      case (code)
         CNT_9:   d = 4'd9;
         CNT_6:   d = 4'd6;
         default: d = 4'd4;
      endcase
      return d;
   endfunction

endpackage

[rtl/eamf_ram.sv]
// ---------------------------------------------------------------------------
// eamf_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data.
// ---------------------------------------------------------------------------
module eamf_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 4096,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/edge_aware_3x3_mean_filter_unit.sv]
// ---------------------------------------------------------------------------
// edge_aware_3x3_mean_filter_unit
// Streaming 3x3 box filter over a raster height map, border aware.
// ---------------------------------------------------------------------------
// usage:
//  - req channel: one request per cycle while req_tready is high; tuser is the action (0 pushes the
//    sample in tdata, 1 is a flush tick). after the last sample of a frame
//    send image_width+1 flush requests to drain the remaining pixels.
//  - rsp channel: rounded mean of the in-bounds neighborhood in tdata,
//    tlast high on the final pixel of the frame. pixels leave in raster
//    order, one row and one column behind the input.
//  - csr channel: always ready; write image_width / image_height only
//    while the block is idle.
//  - throughput: one request per cycle while req_tready is high, set by the
//    single read-modify-write of the two line buffer RAMs per request (read
//    on accept, write back in the following cycle).
//  - pipeline: the request that completes a window passes the window, sum,
//    multiply and correct stages and the result queue before rsp_tvalid.
//  - a stalled receiver fills an 8-entry result queue; req_tready drops
//    only once the queue plus the results in flight reach 8.
//  - reset (synchronous) clears counters, window, queue and sets both
//    dimensions to 2049; line buffers are not cleared, the border test
//    never uses an unwritten entry.
// ---------------------------------------------------------------------------
module edge_aware_3x3_mean_filter_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [eamf_pkg::SAMPLE_BITS-1:0] req_tdata,   // [15:0] sample
   input  logic                             req_tuser,   // [0] action
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [eamf_pkg::SAMPLE_BITS-1:0] rsp_tdata,   // [15:0] avg_height
   output logic                             rsp_tlast,   // is_last
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [eamf_pkg::HEIGHT_BITS-1:0] csr_data
);

   import eamf_pkg::*;

   // configuration
   logic [WIDTH_BITS-1:0]  cfg_width_ff;
   logic [HEIGHT_BITS-1:0] cfg_height_ff;
   logic [COL_BITS-1:0]    w_eff;
   logic [ROW_BITS-1:0]    h_eff;

   // raster counters
   logic [COL_BITS-1:0] in_col_ff, in_col_in;
   logic [ROW_BITS-1:0] in_row_ff, in_row_in;
   logic [COL_BITS-1:0] out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;

   // accept stage
   logic                   accept;
   logic                   do_op;
   logic                   emit;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [SAMPLE_BITS-1:0] bot_val;
   pix_info_type           info;

   // stage 1: line buffer data returns, write back, window shift
   logic                   s1_valid_ff;
   logic                   s1_emit_ff;
   logic [ADDR_BITS-1:0]   s1_addr_ff;
   logic [SAMPLE_BITS-1:0] s1_bot_ff;
   pix_info_type           s1_info_ff;
   logic [SAMPLE_BITS-1:0] prev_rd_data;
   logic [SAMPLE_BITS-1:0] older_rd_data;
   logic [SAMPLE_BITS-1:0] window_ff [9];
   logic [SAMPLE_BITS-1:0] window_in [9];

   // stage 2: masked sum
   logic                   s2_valid_ff;
   pix_info_type           s2_info_ff;
   logic                   col_ok [3];
   logic                   row_ok [3];
   logic [SUM_BITS-1:0]    sum_in;

   // stage 3: rounding add and reciprocal multiply
   logic                   s3_valid_ff;
   logic                   s3_last_ff;
   logic [1:0]             s3_code_ff;
   logic [SUM_BITS-1:0]    s3_sum_ff;
   logic [SUM_BITS-1:0]    round_in;

   // stage 4: quotient correction
   logic                   s4_valid_ff;
   logic                   s4_last_ff;
   logic [1:0]             s4_code_ff;
   logic [SUM_BITS-1:0]    s4_x_ff;
   logic [PROD_BITS-1:0]   s4_prod_ff;
   logic [QUOT_BITS-1:0]   quot0;
   logic [SUM_BITS-1:0]    rem;
   logic [3:0]             div_val;
   logic [SAMPLE_BITS-1:0] avg;

   // result queue
   logic [SAMPLE_BITS:0]     fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0] fifo_count_ff;
   logic [FIFO_CNT_BITS-1:0] inflight;
   logic                     pop;

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(cfg_width_ff) < 32'd2) begin
         w_eff = COL_BITS'(2);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = COL_BITS'(MAX_WIDTH);
      end else begin
         w_eff = COL_BITS'(cfg_width_ff);
      end
      if (cfg_height_ff < HEIGHT_BITS'(2)) begin
         h_eff = ROW_BITS'(2);
      end else begin
         h_eff = ROW_BITS'(cfg_height_ff);
      end
   end

   // ---------------------------------------------------------------------
   // accept stage: counters, line buffer read
   // ---------------------------------------------------------------------
   assign inflight = FIFO_CNT_BITS'(s1_valid_ff & s1_emit_ff) + FIFO_CNT_BITS'(s2_valid_ff)
                   + FIFO_CNT_BITS'(s3_valid_ff) + FIFO_CNT_BITS'(s4_valid_ff);
   assign req_tready = (fifo_count_ff + inflight) < FIFO_CNT_BITS'(FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic [COL_BITS-1:0] ic;
      logic [ROW_BITS-1:0] ir;
      logic [COL_BITS-1:0] oc;
      logic [ROW_BITS-1:0] orow;
      logic                draining;

      ic   = in_col_ff;
      ir   = in_row_ff;
      oc   = out_col_ff;
      orow = out_row_ff;
      if (ic >= w_eff) begin
         ic = '0;
         ir = ir + 1'b1;
      end
      if (oc >= w_eff) begin
         oc   = '0;
         orow = orow + 1'b1;
      end
      if (orow >= h_eff) begin
         ic   = '0;
         ir   = '0;
         oc   = '0;
         orow = '0;
      end
      draining = ir >= h_eff;

      // flush before the frame is complete is a no-op
      do_op   = accept && !((req_tuser == ACT_FLUSH) && !draining);
      rd_addr = ic[ADDR_BITS-1:0];
      bot_val = draining ? '0 : req_tdata;
      emit    = (ir >= ROW_BITS'(2)) || ((ir == ROW_BITS'(1)) && (ic != '0));

      info.col_lo = oc != '0;
      info.col_hi = (oc + 1'b1) < w_eff;
      info.row_lo = orow != '0;
      info.row_hi = (orow + 1'b1) < h_eff;
      info.last   = (orow == h_eff - 1'b1) && (oc == w_eff - 1'b1);

      in_col_in  = ic;
      in_row_in  = ir;
      out_col_in = oc;
      out_row_in = orow;
      if (do_op) begin
         in_col_in = ic + 1'b1;
         if (in_col_in >= w_eff) begin
            in_col_in = '0;
            in_row_in = ir + 1'b1;
         end
         if (emit) begin
            out_col_in = oc + 1'b1;
            if (out_col_in >= w_eff) begin
               out_col_in = '0;
               out_row_in = orow + 1'b1;
            end
            if (info.last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // consecutive operations touch different columns, except the last drain
   // of a frame and the first push of the next (both column 0); that read
   // returns the old entry, which only feeds border taps that are masked
   eamf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_bot_ff),
      .rd_en   (do_op),
      .rd_addr (rd_addr),
      .rd_data (prev_rd_data)
   );

   eamf_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (prev_rd_data),
      .rd_en   (do_op),
      .rd_addr (rd_addr),
      .rd_data (older_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= do_op;
         s1_emit_ff  <= emit;
      end
      s1_addr_ff <= rd_addr;
      s1_bot_ff  <= bot_val;
      s1_info_ff <= info;
   end

   // ---------------------------------------------------------------------
   // stage 1: window shift, column 0 oldest, row 0 top
   // ---------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         window_in[k] = window_ff[k + 3];
      end
      window_in[6] = older_rd_data;
      window_in[7] = prev_rd_data;
      window_in[8] = s1_bot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            window_ff[k] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            window_ff <= window_in;
         end
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
      s2_info_ff <= s1_info_ff;
   end

   // ---------------------------------------------------------------------
   // stage 2: sum of in-bounds samples
   // ---------------------------------------------------------------------
   always_comb begin
      col_ok[0] = s2_info_ff.col_lo;
      col_ok[1] = 1'b1;
      col_ok[2] = s2_info_ff.col_hi;
      row_ok[0] = s2_info_ff.row_lo;
      row_ok[1] = 1'b1;
      row_ok[2] = s2_info_ff.row_hi;
      sum_in = '0;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            if (col_ok[j] && row_ok[k]) begin
               sum_in = sum_in + SUM_BITS'(window_ff[j * 3 + k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_sum_ff  <= sum_in;
      s3_last_ff <= s2_info_ff.last;
      s3_code_ff <= count_code(s2_info_ff.col_lo && s2_info_ff.col_hi,
                               s2_info_ff.row_lo && s2_info_ff.row_hi);
   end

   // ---------------------------------------------------------------------
   // stage 3: add half the count, multiply by reciprocal
   // ---------------------------------------------------------------------
   assign round_in = s3_sum_ff + SUM_BITS'(divisor_of(s3_code_ff) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_x_ff    <= round_in;
      s4_prod_ff <= PROD_BITS'(round_in) * PROD_BITS'(recip_of(s3_code_ff));
      s4_last_ff <= s3_last_ff;
      s4_code_ff <= s3_code_ff;
   end

   // ---------------------------------------------------------------------
   // stage 4: estimate is exact or one low, fix with one compare
   // ---------------------------------------------------------------------
   always_comb begin
      logic [QUOT_BITS-1:0] quot;
      div_val = divisor_of(s4_code_ff);
      quot0   = s4_prod_ff[PROD_BITS-1:RECIP_SHIFT];
      rem     = s4_x_ff - (SUM_BITS'(quot0) * SUM_BITS'(div_val));
      quot    = quot0;
      if (rem >= SUM_BITS'(div_val)) begin
         quot = quot0 + 1'b1;
      end
      avg = quot[SAMPLE_BITS-1:0];
   end

   // ---------------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------------
   assign rsp_tvalid = fifo_count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = fifo_mem_ff[rd_ptr_ff][SAMPLE_BITS-1:0];
   assign rsp_tlast  = fifo_mem_ff[rd_ptr_ff][SAMPLE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (s4_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({s4_valid_ff, pop})
            2'b10:   fifo_count_ff <= fifo_count_ff + 1'b1;
            2'b01:   fifo_count_ff <= fifo_count_ff - 1'b1;
            default: fifo_count_ff <= fifo_count_ff;
         endcase
      end
      if (s4_valid_ff) begin
         fifo_mem_ff[wr_ptr_ff] <= {s4_last_ff, avg};
      end
   end

endmodule

[dv/tb_edge_aware_3x3_mean_filter_unit.sv]
// ---------------------------------------------------------------------------
// tb_edge_aware_3x3_mean_filter_unit
// Self-checking bench for the border-aware 3x3 mean filter. A scoreboard
// class mirrors the line buffers, window and raster counters to predict each
// averaged pixel. Whole frames are streamed under several frame sizes and
// backpressure mixes, and every result is compared in order.
// ---------------------------------------------------------------------------
module tb_edge_aware_3x3_mean_filter_unit;

   typedef struct packed {
      logic [eamf_pkg::SAMPLE_BITS-1:0] avg;
      logic                             last;
   } pixel_result_type;

   class mean_filter_scoreboard;
      bit [eamf_pkg::WIDTH_BITS-1:0]  width_reg;
      bit [eamf_pkg::HEIGHT_BITS-1:0] height_reg;
      bit [15:0]                      line_prev[eamf_pkg::MAX_WIDTH];
      bit [15:0]                      line_older[eamf_pkg::MAX_WIDTH];
      bit [15:0]                      win[9];
      int unsigned                    in_col, in_row, out_col, out_row;
      pixel_result_type               expected_pixels[$];
      int unsigned                    errors;

      function new();
         width_reg  = eamf_pkg::WIDTH_RESET;
         height_reg = eamf_pkg::HEIGHT_RESET;
         errors     = 0;
         clear_position();
      endfunction

      function void clear_position();
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
      endtask

      function void set_register(bit idx, bit [15:0] value);
         if (idx == eamf_pkg::CSR_IMAGE_WIDTH) begin
            width_reg = value[eamf_pkg::WIDTH_BITS-1:0];
         end else begin
            height_reg = value;
         end
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = width_reg;
         if (w < 2) w = 2;
         if (w > eamf_pkg::MAX_WIDTH) w = eamf_pkg::MAX_WIDTH;
         return w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = height_reg;
         if (h < 2) h = 2;
         return h;
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      // advance the raster model by one accepted request
      function void note_request(bit act, bit [15:0] smp);
         int unsigned      w, h, c, sum, num;
         bit               draining, emit;
         bit [15:0]        top, mid, bot;
         int               pc, pr;
         pixel_result_type res;
         w = eff_width();
         h = eff_height();
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         if (out_row >= h) clear_position();
         draining = (in_row >= h);
         // a flush before the frame is complete is ignored
         if (act == eamf_pkg::ACT_FLUSH && !draining) return;
         c   = in_col;
         top = line_older[c];
         mid = line_prev[c];
         bot = draining ? 16'd0 : smp;
         line_older[c] = mid;
         line_prev[c]  = bot;
         for (int k = 0; k < 6; k++) win[k] = win[k+3];
         win[6] = top;
         win[7] = mid;
         win[8] = bot;
         emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (!emit) return;
         sum = 0;
         num = 0;
         for (int j = 0; j < 3; j++) begin
            pc = int'(out_col) - 1 + j;
            if (pc < 0 || pc >= int'(w)) continue;
            for (int k = 0; k < 3; k++) begin
               pr = int'(out_row) - 1 + k;
               if (pr < 0 || pr >= int'(h)) continue;
               sum += win[j*3+k];
               num++;
            end
         end
         res.last = (out_row == h - 1) && (out_col == w - 1);
         res.avg  = (num == 0) ? 16'd0 : 16'((sum + num / 2) / num);
         expected_pixels = {expected_pixels, res};
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         if (res.last) clear_position();
      endfunction

      task check_result(logic [15:0] data, logic last);
         pixel_result_type exp_px;
         if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected pixel avg=%0d last=%0b", data, last));
            return;
         end
         exp_px = expected_pixels.pop_front();
         if (data !== exp_px.avg) begin
            report($sformatf("avg_height got %0d want %0d", data, exp_px.avg));
         end
         if (last !== exp_px.last) begin
            report($sformatf("is_last got %b want %b", last, exp_px.last));
         end
      endtask
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [eamf_pkg::SAMPLE_BITS-1:0] req_tdata  = '0;
   logic                             req_tuser  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [eamf_pkg::SAMPLE_BITS-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic                             csr_index  = 1'b0;
   logic [eamf_pkg::HEIGHT_BITS-1:0] csr_data   = '0;

   mean_filter_scoreboard sb;
   int unsigned           send_idle_pct  = 0;
   int unsigned           recv_stall_pct = 0;
   int unsigned           requests_sent  = 0;

   edge_aware_3x3_mean_filter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      #32_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [15:0] pick_height();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return 16'h0000;
      if (roll < 40) return 16'hFFFF;
      // tiny values make rounding ties common
      if (roll < 55) return 16'($urandom_range(8));
      return 16'($urandom);
   endfunction

   // valid stays up after acceptance; the caller lowers it or sends again
   task automatic send_request(bit act, logic [15:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, smp);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // flushes with no result may still be in the pipeline
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(bit idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic configure(logic [15:0] width_val, logic [15:0] height_val);
      wait_idle();
      write_register(eamf_pkg::CSR_IMAGE_WIDTH, width_val);
      write_register(eamf_pkg::CSR_IMAGE_HEIGHT, height_val);
   endtask

   // one whole frame, then width+1 drain requests mixing flushes and late pushes
   task automatic run_frame(int unsigned early_pct, bit pause_mid);
      int unsigned w, h, total;
      w     = sb.eff_width();
      h     = sb.eff_height();
      total = w * h;
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(99) < early_pct) begin
            send_request(eamf_pkg::ACT_FLUSH, 16'($urandom));
         end
         if (pause_mid && i == total / 2) wait_idle();
         send_request(eamf_pkg::ACT_PUSH, pick_height());
      end
      for (int unsigned k = 0; k <= w; k++) begin
         send_request(($urandom_range(3) == 0) ? eamf_pkg::ACT_PUSH
                                               : eamf_pkg::ACT_FLUSH,
                      16'($urandom));
      end
      // flushes after the frame has closed are ignored
      repeat ($urandom_range(2)) send_request(eamf_pkg::ACT_FLUSH, 16'($urandom));
   endtask

   initial begin
      int unsigned send_pcts[4];
      int unsigned recv_pcts[4];
      int unsigned target;
      logic [15:0] wv, hv;
      send_pcts = '{0, 82, 0, 8};
      recv_pcts = '{0, 0, 82, 8};
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 frame from under-range dimensions, early flush and late push
      configure(16'd0, 16'd1);
      send_request(eamf_pkg::ACT_PUSH, 16'hFFFF);
      send_request(eamf_pkg::ACT_FLUSH, 16'h1234);
      send_request(eamf_pkg::ACT_PUSH, 16'h0000);
      send_request(eamf_pkg::ACT_PUSH, 16'hFFFF);
      send_request(eamf_pkg::ACT_PUSH, 16'hFFFE);
      send_request(eamf_pkg::ACT_PUSH, 16'h5A5A);
      send_request(eamf_pkg::ACT_FLUSH, 16'h0000);
      send_request(eamf_pkg::ACT_FLUSH, 16'hA5A5);
      send_request(eamf_pkg::ACT_FLUSH, 16'hFFFF);

      // 3x3 with junk above the width field, pause mid-frame until drained
      configure(16'hE003, 16'd3);
      run_frame(20, 1'b1);

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         send_idle_pct  = send_pcts[p];
         recv_stall_pct = recv_pcts[p];
         target = requests_sent + 440;
         while (requests_sent < target) begin
            wv = ($urandom_range(7) == 0) ? 16'($urandom_range(11, 40))
                                          : 16'($urandom_range(0, 10));
            if ($urandom_range(5) == 0) wv[15:13] = 3'($urandom);
            hv = ($urandom_range(7) == 0) ? 16'($urandom_range(6, 9))
                                          : 16'($urandom_range(0, 5));
            case ($urandom_range(3))
               0: begin
                  wait_idle();
                  write_register(eamf_pkg::CSR_IMAGE_WIDTH, wv);
               end
               1: begin
                  wait_idle();
                  write_register(eamf_pkg::CSR_IMAGE_HEIGHT, hv);
               end
               default: configure(wv, hv);
            endcase
            run_frame(8, 1'b0);
         end
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/eamf_pkg.sv
rtl/eamf_ram.sv
rtl/edge_aware_3x3_mean_filter_unit.sv
dv/tb_edge_aware_3x3_mean_filter_unit.sv
